[rtl/view_frustum_cull_test_core_macros.svh]
// assertion macros for the frustum cull core
// expects clk and arst_n in the scope of use
`ifndef VIEW_FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define VIEW_FRUSTUM_CULL_TEST_CORE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define VFCT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define VFCT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vfct_pkg.sv]
// shared constants, types and plane coefficient function of the frustum cull core
// no dependencies
`default_nettype none

package vfct_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	localparam int NUM_CFG   = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	localparam int ELEM_W      = 32;
	localparam int COEF_W      = ELEM_W + 1;
	localparam int LO_W        = 16;
	localparam int NUM_AXES    = 3;
	localparam int NUM_TERMS   = NUM_AXES + 1;
	localparam int NUM_PLANES  = 6;
	localparam int PLANE_IDX_W = 3;

	localparam logic [1:0] MODE_POINT = 2'd0;
	localparam logic [1:0] MODE_BOX   = 2'd1;
	localparam logic [1:0] MODE_CUBE  = 2'd2;

	localparam logic [PLANE_IDX_W-1:0] PL_LEFT   = 3'd0;
	localparam logic [PLANE_IDX_W-1:0] PL_RIGHT  = 3'd1;
	localparam logic [PLANE_IDX_W-1:0] PL_BOTTOM = 3'd2;
	localparam logic [PLANE_IDX_W-1:0] PL_TOP    = 3'd3;
	localparam logic [PLANE_IDX_W-1:0] PL_NEAR   = 3'd4;
	localparam logic [PLANE_IDX_W-1:0] PL_FAR    = 3'd5;

	typedef logic [COEF_W-1:0] coef_t;
	// x, y, z normal terms then the offset term
	typedef coef_t [NUM_TERMS-1:0] plane_t;

	// identity matrix, two q16.16 elements per register
	localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = {
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	// one coefficient of a plane from the four elements of one matrix row
	function automatic coef_t plane_coef(
		input logic [PLANE_IDX_W-1:0] pl,
		input logic [ELEM_W-1:0]      e0,
		input logic [ELEM_W-1:0]      e1,
		input logic [ELEM_W-1:0]      e2,
		input logic [ELEM_W-1:0]      w
	);
		coef_t x0;
		coef_t x1;
		coef_t x2;
		coef_t xw;
		coef_t r;
		x0 = {e0[ELEM_W-1], e0};
		x1 = {e1[ELEM_W-1], e1};
		x2 = {e2[ELEM_W-1], e2};
		xw = {w[ELEM_W-1], w};
		unique case (pl)
			PL_LEFT:   r = xw + x0;
			PL_RIGHT:  r = xw - x0;
			PL_BOTTOM: r = xw + x1;
			PL_TOP:    r = xw - x1;
			PL_NEAR:   r = x2;
			PL_FAR:    r = xw - x2;
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/view_frustum_cull_test_core.sv]
// frustum cull core: one query word per cycle, one result word per query
// a taken start is registered in one input stage, then passes six plane cells of three stages
// each; every cell hands the operands on to the next from its first stage
// throughput: one word every cycle, set by the fully pipelined plane cells
// reset: async active low, loads the identity matrix, empties the chain; busy is set
// by reset, cleared by every clock edge out of reset; no output back-pressure
`default_nettype none

module view_frustum_cull_test_core #(
	parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic signed [COORD_WIDTH-1:0]  center_x,
	input  logic signed [COORD_WIDTH-1:0]  center_y,
	input  logic signed [COORD_WIDTH-1:0]  center_z,
	input  logic [COORD_WIDTH-2:0]         half_x,
	input  logic [COORD_WIDTH-2:0]         half_y,
	input  logic [COORD_WIDTH-2:0]         half_z,
	input  logic                           cfg_we,
	input  logic [vfct_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [vfct_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                           done,
	output logic                           inside_res
);
	import vfct_pkg::*;

	`include "view_frustum_cull_test_core_macros.svh"

	localparam int OP_W = COORD_WIDTH + 1;
	// cycles from accepted start to result strobe
	localparam int LAT = NUM_PLANES + 3;

	// matrix registers, two elements each
	logic [NUM_CFG-1:0][CFG_W-1:0] cfg_q;
	plane_t [NUM_PLANES-1:0]       planes;

	logic busy_q;
	logic accept;

	// half sizes after mode selection
	logic [COORD_WIDTH-2:0] hs [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] ctr [NUM_AXES];

	// input stage: center plus and minus half size per axis
	logic                          vld_s1;
	logic [NUM_AXES-1:0][OP_W-1:0] pos_s1;
	logic [NUM_AXES-1:0][OP_W-1:0] neg_s1;

	// links between the cells of the chain
	logic                          op_vld_c [NUM_PLANES+1];
	logic [NUM_AXES-1:0][OP_W-1:0] op_pos_c [NUM_PLANES+1];
	logic [NUM_AXES-1:0][OP_W-1:0] op_neg_c [NUM_PLANES+1];
	logic                          flag_c   [NUM_PLANES+1];
	logic [NUM_PLANES-1:0]         res_vld;

	// a word is taken whenever start is high and busy is low
	assign accept = start & ~busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// config writes land directly; user writes only while the chain is empty, not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	vfct_planes u_planes (
		.clk    (clk),
		.cfg    (cfg_q),
		.planes (planes)
	);

	// point uses zero extent, cube repeats the radius, box and the spare code use all three
	always_comb begin
		ctr[0] = center_x;
		ctr[1] = center_y;
		ctr[2] = center_z;
		unique case (mode)
			MODE_POINT: begin
				hs[0] = '0;
				hs[1] = '0;
				hs[2] = '0;
			end
			MODE_CUBE: begin
				hs[0] = half_x;
				hs[1] = half_x;
				hs[2] = half_x;
			end
			MODE_BOX: begin
				hs[0] = half_x;
				hs[1] = half_y;
				hs[2] = half_z;
			end
			default: begin
				hs[0] = half_x;
				hs[1] = half_y;
				hs[2] = half_z;
			end
		endcase
	end

	// both candidate far corners per axis; each cell picks by its own coefficient sign
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) begin
			pos_s1[i] <= OP_W'(ctr[i]) + OP_W'(hs[i]);
			neg_s1[i] <= OP_W'(ctr[i]) - OP_W'(hs[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	assign op_vld_c[0] = vld_s1;
	assign op_pos_c[0] = pos_s1;
	assign op_neg_c[0] = neg_s1;
	// first cell starts from "inside"
	assign flag_c[0]   = 1'b1;

	// six plane cells: operands pass on from each cell's first stage, the flag from its last
	for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
		vfct_cell #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.plane        (planes[k]),
			.op_vld       (op_vld_c[k]),
			.op_pos       (op_pos_c[k]),
			.op_neg       (op_neg_c[k]),
			.flag_in      (flag_c[k]),
			.op_vld_out   (op_vld_c[k+1]),
			.op_pos_out   (op_pos_c[k+1]),
			.op_neg_out   (op_neg_c[k+1]),
			.flag_out     (flag_c[k+1]),
			.flag_vld_out (res_vld[k])
		);
	end

	// result word straight from the last cell's registers
	assign done       = res_vld[NUM_PLANES-1];
	assign inside_res = flag_c[NUM_PLANES];

	// every accepted word gives exactly one strobe, at fixed latency
	`VFCT_ASSERT_IMP(a_accept_gives_done, accept, ##LAT done, "strobe missing after accepted word")
	`VFCT_ASSERT_IMP(a_done_had_accept, done, $past(accept, LAT), "strobe without accepted word")
	// the last cell finishes behind the first by the operand skew of the cells after it
	`VFCT_ASSERT_NXT(a_chain_skew, res_vld[0], ##(NUM_PLANES-2) res_vld[NUM_PLANES-1],
		"chain cells out of step")

endmodule

`default_nettype wire

[rtl/vfct_cell.sv]
// one plane cell of the cull chain: signed distance of the far corner, and-ed into the flag
// depends on vfct_pkg
`default_nettype none

module vfct_cell #(
	parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  vfct_pkg::plane_t                          plane,
	input  logic                                      op_vld,
	input  logic [vfct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] op_pos,
	input  logic [vfct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] op_neg,
	input  logic                                      flag_in,
	output logic                                      op_vld_out,
	output logic [vfct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] op_pos_out,
	output logic [vfct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] op_neg_out,
	output logic                                      flag_out,
	output logic                                      flag_vld_out
);
	import vfct_pkg::*;

	localparam int OP_W  = COORD_WIDTH + 1;
	localparam int PP_W  = OP_W + COEF_W - LO_W;
	localparam int AX_W  = OP_W + COEF_W;
	localparam int ACC_W = AX_W + 2;

	logic [OP_W-1:0]        op_sel [NUM_AXES];
	logic signed [PP_W-1:0] lo_ext [NUM_AXES];
	logic signed [PP_W-1:0] hi_ext [NUM_AXES];
	logic signed [PP_W-1:0] op_ext [NUM_AXES];

	logic signed [PP_W-1:0] pp_lo_s1 [NUM_AXES];
	logic signed [PP_W-1:0] pp_hi_s1 [NUM_AXES];
	logic [NUM_AXES-1:0][OP_W-1:0] pos_s1;
	logic [NUM_AXES-1:0][OP_W-1:0] neg_s1;
	logic                   vld_s1;

	logic signed [AX_W-1:0] ax_s2 [NUM_AXES];
	logic                   vld_s2;

	logic signed [ACC_W-1:0] dist_acc;
	logic                    flag_s3;
	logic                    vld_s3;

	// far corner: center plus half size on a non-negative coefficient, minus otherwise
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			op_sel[i] = plane[i][COEF_W-1] ? op_neg[i] : op_pos[i];
			lo_ext[i] = PP_W'($signed({1'b0, plane[i][LO_W-1:0]}));
			hi_ext[i] = PP_W'($signed(plane[i][COEF_W-1:LO_W]));
			op_ext[i] = PP_W'($signed(op_sel[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) begin
			pp_lo_s1[i] <= lo_ext[i] * op_ext[i];
			pp_hi_s1[i] <= hi_ext[i] * op_ext[i];
			ax_s2[i]    <= (AX_W'(pp_hi_s1[i]) <<< LO_W) + AX_W'(pp_lo_s1[i]);
		end
		pos_s1  <= op_pos;
		neg_s1  <= op_neg;
		flag_s3 <= flag_in & ~dist_acc[ACC_W-1];
	end

	always_comb begin
		dist_acc = ACC_W'(ax_s2[0]) + ACC_W'(ax_s2[1]) + ACC_W'(ax_s2[2])
			+ (ACC_W'($signed(plane[NUM_AXES])) <<< LO_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= op_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign op_vld_out   = vld_s1;
	assign op_pos_out   = pos_s1;
	assign op_neg_out   = neg_s1;
	assign flag_out     = flag_s3;
	assign flag_vld_out = vld_s3;

endmodule

`default_nettype wire

[rtl/vfct_planes.sv]
// plane coefficients built from the matrix registers, registered once per cycle
// depends on vfct_pkg
`default_nettype none

module vfct_planes (
	input  logic                                                  clk,
	input  logic [vfct_pkg::NUM_CFG-1:0][vfct_pkg::CFG_W-1:0]     cfg,
	output vfct_pkg::plane_t [vfct_pkg::NUM_PLANES-1:0]           planes
);
	import vfct_pkg::*;

	plane_t [NUM_PLANES-1:0] planes_q;

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		for (genvar r = 0; r < NUM_TERMS; r++) begin : g_row
			always_ff @(posedge clk) begin
				planes_q[p][r] <= plane_coef(PLANE_IDX_W'(p),
					cfg[2*r][ELEM_W-1:0],
					cfg[2*r][2*ELEM_W-1:ELEM_W],
					cfg[2*r+1][ELEM_W-1:0],
					cfg[2*r+1][2*ELEM_W-1:ELEM_W]);
			end
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

[tb/tb_view_frustum_cull_test_core.sv]
// self-checking testbench for the frustum cull core: directed and random queries
// over several view-projection matrices, predicted in 128-bit exact arithmetic
// depends on rtl/vfct_pkg.sv and rtl/view_frustum_cull_test_core.sv
module tb_view_frustum_cull_test_core;
	timeunit 1ns;
	timeprecision 1ps;

	import vfct_pkg::*;

	localparam int CW              = COORD_WIDTH_DEF;
	localparam int ONE             = 65536;       // 1.0 in q16.16
	localparam int PIPE_LAT        = 9;           // start taken to done strobe
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int NUM_PHASES      = 11;

	// mode code outside the documented three, handled as a box
	localparam logic [1:0] MODE_BOX_ALIAS = 2'd3;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-2:0]        HALF_MAX  = {(CW-1){1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW1_LO, REG_ROW1_HI, REG_ROW2_LO, REG_ROW2_HI,
		REG_ROW3_LO, REG_ROW3_HI, REG_ROW4_LO, REG_ROW4_HI
	} cfg_reg_e;

	typedef enum int {
		MAT_ZERO, MAT_NEG_OFFSET, MAT_MAX, MAT_MIN, MAT_PERSP, MAT_SMALL, MAT_FULL
	} mat_kind_e;

	// one query word as presented on the payload ports
	typedef struct {
		logic [1:0]           mode;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
		logic [CW-2:0]        half_x;
		logic [CW-2:0]        half_y;
		logic [CW-2:0]        half_z;
	} query_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [1:0]           mode      = '0;
	logic signed [CW-1:0] center_x  = '0;
	logic signed [CW-1:0] center_y  = '0;
	logic signed [CW-1:0] center_z  = '0;
	logic [CW-2:0]        half_x    = '0;
	logic [CW-2:0]        half_y    = '0;
	logic [CW-2:0]        half_z    = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 done;
	logic                 inside_res;

	// queries waiting for the driver, and inside flags waiting for their strobe
	query_t query_q[$];
	logic   inside_exp_q[$];

	// copy of the matrix registers as the core should hold them
	logic [CFG_W-1:0] cfg_shadow[NUM_CFG];

	query_t head_q;
	int     gap_left  = 0;
	bit     no_idle   = 1'b0;
	int     fail_cnt  = 0;
	int     quiet_cnt = 0;

	view_frustum_cull_test_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.center_x   (center_x),
		.center_y   (center_y),
		.center_z   (center_z),
		.half_x     (half_x),
		.half_y     (half_y),
		.half_z     (half_z),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.inside_res (inside_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact plane test: every sum is done in 128 bits so nothing can wrap
	function automatic logic predict_inside(input query_t q);
		int                  el[4][4];
		logic signed [127:0] ctr[3];
		logic signed [127:0] hs[3];
		logic signed [127:0] coef;
		logic signed [127:0] coef_mag;
		logic signed [127:0] acc;
		logic [2:0]          pl;
		logic                in_frustum;
		in_frustum = 1'b1;
		// two elements per register, low half first
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				el[r][c] = c[0] ? cfg_shadow[r*2 + c/2][63:32] : cfg_shadow[r*2 + c/2][31:0];
			end
		end
		ctr[0] = q.center_x;
		ctr[1] = q.center_y;
		ctr[2] = q.center_z;
		hs[0]  = q.half_x;
		hs[1]  = q.half_y;
		hs[2]  = q.half_z;
		// a point has no extent, a cube takes its radius on every axis
		if (q.mode == MODE_POINT) begin
			hs[0] = '0;
			hs[1] = '0;
			hs[2] = '0;
		end else if (q.mode == MODE_CUBE) begin
			hs[1] = hs[0];
			hs[2] = hs[0];
		end
		for (int p = 0; p < NUM_PLANES; p++) begin
			pl  = p[2:0];
			acc = '0;
			for (int r = 0; r < 4; r++) begin
				case (pl)
					PL_LEFT:   coef = longint'(el[r][3]) + longint'(el[r][0]);
					PL_RIGHT:  coef = longint'(el[r][3]) - longint'(el[r][0]);
					PL_BOTTOM: coef = longint'(el[r][3]) + longint'(el[r][1]);
					PL_TOP:    coef = longint'(el[r][3]) - longint'(el[r][1]);
					PL_NEAR:   coef = el[r][2];
					default:   coef = longint'(el[r][3]) - longint'(el[r][2]);
				endcase
				if (r < 3) begin
					// farthest corner along the normal
					coef_mag = coef[127] ? -coef : coef;
					acc      = acc + coef * ctr[r] + coef_mag * hs[r];
				end else begin
					acc = acc + coef * 65536;
				end
			end
			if (acc[127])
				in_frustum = 1'b0;
		end
		return in_frustum;
	endfunction

	function automatic query_t make_query(
		input logic [1:0]           m,
		input logic signed [CW-1:0] cx,
		input logic signed [CW-1:0] cy,
		input logic signed [CW-1:0] cz,
		input logic [CW-2:0]        hx,
		input logic [CW-2:0]        hy,
		input logic [CW-2:0]        hz
	);
		query_t q;
		q.mode     = m;
		q.center_x = cx;
		q.center_y = cy;
		q.center_z = cz;
		q.half_x   = hx;
		q.half_y   = hy;
		q.half_z   = hz;
		return q;
	endfunction

	// mostly near the unit volume so both outcomes show up, some full range
	function automatic logic signed [CW-1:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 5)
			return $urandom_range(0, 16*ONE) - 8*ONE;
		else if (sel <= 7)
			return $urandom;
		else if (sel == 8)
			return COORD_MAX;
		else
			return COORD_MIN;
	endfunction

	function automatic logic [CW-2:0] rand_half();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel <= 6)
			return (CW-1)'($urandom_range(0, 4*ONE));
		else if (sel <= 8)
			return (CW-1)'($urandom);
		else
			return HALF_MAX;
	endfunction

	function automatic query_t rand_query();
		int         sel;
		logic [1:0] m;
		sel = $urandom_range(0, 9);
		if (sel <= 2)
			m = MODE_POINT;
		else if (sel <= 5)
			m = MODE_BOX;
		else if (sel <= 8)
			m = MODE_CUBE;
		else
			m = MODE_BOX_ALIAS;
		return make_query(m, rand_coord(), rand_coord(), rand_coord(),
			rand_half(), rand_half(), rand_half());
	endfunction

	task automatic build_matrix(input mat_kind_e kind, output int mat[4][4]);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (kind)
					MAT_MAX:   mat[r][c] = 32'h7fff_ffff;
					MAT_MIN:   mat[r][c] = 32'h8000_0000;
					MAT_SMALL: mat[r][c] = $urandom_range(0, 4*ONE) - 2*ONE;
					MAT_FULL:  mat[r][c] = $urandom;
					default:   mat[r][c] = 0;
				endcase
			end
		end
		case (kind)
			// zero normals everywhere, the offset alone decides
			MAT_NEG_OFFSET: mat[3][3] = -ONE;
			// rough perspective: w follows z, some skew in the third row
			MAT_PERSP: begin
				mat[0][0] = $urandom_range(ONE/2, 2*ONE);
				mat[1][1] = $urandom_range(ONE/2, 2*ONE);
				mat[2][0] = $urandom_range(0, ONE/4) - ONE/8;
				mat[2][1] = $urandom_range(0, ONE/4) - ONE/8;
				mat[2][2] = $urandom_range(ONE, ONE + ONE/8);
				mat[2][3] = ONE;
				mat[3][2] = -$urandom_range(0, ONE/4);
			end
			default: ;
		endcase
	endtask

	task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we          <= 1'b1;
		cfg_idx         <= idx;
		cfg_wdata       <= val;
		cfg_shadow[idx]  = val;
	endtask

	// all eight registers, element in the low half first
	task automatic load_matrix(input int mat[4][4]);
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 2; k++) begin
				cfg_write(cfg_reg_e'(r*2 + k), {mat[r][2*k+1], mat[r][2*k]});
			end
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every query has come back and the chain is empty
	task automatic drain_pipe();
		while (query_q.size() != 0 || inside_exp_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// driver: presents the head of the query queue, random idle bursts after a word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left  = 0;
		end else begin
			if (start && !busy) begin
				// word taken at this edge, its flag follows the current matrix
				head_q = query_q.pop_front();
				inside_exp_q.push_back(predict_inside(head_q));
				if (!no_idle && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 16);
			end
			if (no_idle)
				gap_left = 0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (query_q.size() != 0) begin
				start    <= 1'b1;
				mode     <= query_q[0].mode;
				center_x <= query_q[0].center_x;
				center_y <= query_q[0].center_y;
				center_z <= query_q[0].center_z;
				half_x   <= query_q[0].half_x;
				half_y   <= query_q[0].half_y;
				half_z   <= query_q[0].half_z;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each strobe is matched against the oldest pending flag
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (inside_exp_q.size() == 0) begin
				$error("inside_res: result word with no query pending, actual %0b", inside_res);
				fail_cnt++;
			end else if (inside_res !== inside_exp_q[0]) begin
				$error("inside_res mismatch: expected %0b actual %0b",
					inside_exp_q[0], inside_res);
				fail_cnt++;
				void'(inside_exp_q.pop_front());
			end else begin
				void'(inside_exp_q.pop_front());
			end
		end
	end

	// watchdog: too long with neither a query taken nor a result seen
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= WATCHDOG_CYCLES) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		mat_kind_e phase_kind[NUM_PHASES];
		int        mat[4][4];
		int        n_items;
		phase_kind = '{MAT_ZERO, MAT_NEG_OFFSET, MAT_MAX, MAT_MIN, MAT_PERSP, MAT_SMALL,
			MAT_FULL, MAT_PERSP, MAT_SMALL, MAT_PERSP, MAT_PERSP};
		// core comes out of reset holding the identity matrix
		for (int i = 0; i < NUM_CFG; i++)
			cfg_shadow[i] = CFG_RESET[i];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity frustum: x and y in [-1, 1], z in [0, 1]
		query_q.push_back(make_query(MODE_POINT, 0, 0, 0, 0, 0, 0));
		// distance exactly zero still counts as inside
		query_q.push_back(make_query(MODE_POINT, ONE, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(MODE_POINT, ONE + 1, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(MODE_POINT, -ONE, -ONE, ONE, 0, 0, 0));
		query_q.push_back(make_query(MODE_POINT, 0, 0, -1, 0, 0, 0));
		query_q.push_back(make_query(MODE_POINT, ONE, -ONE, ONE, 0, 0, 0));
		// point ignores half sizes
		query_q.push_back(make_query(MODE_POINT, 2*ONE, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
		// box just touching, then one lsb short
		query_q.push_back(make_query(MODE_BOX, 3*ONE, 0, 0, 2*ONE, 0, 0));
		query_q.push_back(make_query(MODE_BOX, 3*ONE, 0, 0, 2*ONE - 1, HALF_MAX, HALF_MAX));
		query_q.push_back(make_query(MODE_BOX, 0, -3*ONE, 0, 0, 2*ONE - 1, 0));
		// mode three behaves as a box
		query_q.push_back(make_query(MODE_BOX_ALIAS, 3*ONE, 0, 0, 2*ONE, 0, 0));
		query_q.push_back(make_query(MODE_BOX_ALIAS, 3*ONE, 0, 0, 2*ONE - 1, 0, 0));
		query_q.push_back(make_query(MODE_BOX_ALIAS, 0, 0, 2*ONE, 0, 0, ONE));
		// cube uses half_x on all axes, the other half sizes are ignored
		query_q.push_back(make_query(MODE_CUBE, 0, 0, -ONE, ONE, 0, 0));
		query_q.push_back(make_query(MODE_CUBE, 0, 0, -ONE, ONE - 1, HALF_MAX, HALF_MAX));
		query_q.push_back(make_query(MODE_CUBE, 0, 3*ONE, 0, 2*ONE, 0, 0));
		// coordinate extremes
		query_q.push_back(make_query(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
		query_q.push_back(make_query(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
		query_q.push_back(make_query(MODE_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
			HALF_MAX, HALF_MAX, HALF_MAX));
		query_q.push_back(make_query(MODE_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
			HALF_MAX, HALF_MAX, HALF_MAX));
		query_q.push_back(make_query(MODE_CUBE, COORD_MIN, COORD_MAX, COORD_MIN,
			HALF_MAX, 0, 0));
		query_q.push_back(make_query(MODE_BOX_ALIAS, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
		drain_pipe();

		// one matrix per phase, loaded only while the core is empty
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			build_matrix(phase_kind[ph], mat);
			load_matrix(mat);
			case (phase_kind[ph])
				MAT_ZERO, MAT_NEG_OFFSET: n_items = 30;
				MAT_MAX, MAT_MIN:         n_items = 60;
				MAT_FULL:                 n_items = 100;
				default:                  n_items = 200;
			endcase
			// last phase runs back to back
			if (ph == NUM_PHASES - 1)
				no_idle = 1'b1;
			@(posedge clk);
			for (int i = 0; i < n_items; i++)
				query_q.push_back(rand_query());
			drain_pipe();
		end

		repeat (2 * PIPE_LAT) @(posedge clk);
		if (fail_cnt == 0 && inside_exp_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
